@@ rtl/dha_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dha_pkg
// Shared widths, the block normalization helpers and the arctangent table
// of the dihedral angle pipeline.
// ----------------------------------------------------------------------------
package dha_pkg;

	localparam int COORD_W      = 32;
	localparam int DIFF_W       = COORD_W + 1;
	localparam int NORM_BITS    = 30;
	localparam int NV_W         = NORM_BITS + 1;
	localparam int PROD_W       = 2 * NV_W;
	localparam int DOT_W        = PROD_W + 1;
	localparam int K_W          = 6;
	localparam int SQ_W         = DOT_W;
	localparam int SQRT_STEPS   = NV_W;
	localparam int ROOT_W       = NV_W;
	localparam int CORDIC_STEPS = 32;
	localparam int CX_W         = NV_W + 5;
	localparam int Z_W          = 35;
	localparam int ZC_W         = 33;
	localparam int ANGLE_W      = 25;
	localparam int OUT_FRAC     = 16;
	localparam int DEG_SCALE    = 180;
	localparam int DEG_W        = ZC_W + 8;

	localparam logic signed [Z_W-1:0] Z_RIGHT = Z_W'(64'd1 << 31);
	localparam logic signed [Z_W-1:0] Z_FULL  = Z_W'(64'd1 << 32);
	localparam logic signed [ANGLE_W-1:0] ANGLE_MAX = ANGLE_W'(11796480);

	typedef struct packed {
		logic                   undef;
		logic                   s_pos;
		logic signed [NV_W-1:0] x;
	} dha_sq_tag_t;

	typedef struct packed {
		logic undef;
		logic s_pos;
	} dha_cd_tag_t;

	typedef logic [Z_W-1:0] rot_tab_t [CORDIC_STEPS];

	function automatic logic [K_W-1:0] norm_k(input logic [DOT_W-1:0] m);
		logic [K_W-1:0] len;
		len = '0;
		for (int i = 0; i < DOT_W; i++) begin
			if (m[i]) begin
				len = K_W'(i + 1);
			end
		end
		return (len > K_W'(NORM_BITS)) ? len - K_W'(NORM_BITS) : '0;
	endfunction

	function automatic logic signed [NV_W-1:0] norm_apply(input logic [DOT_W-1:0] m,
			input logic neg, input logic [K_W-1:0] k);
		logic [DOT_W-1:0] q;
		logic [NV_W-1:0]  q_n;
		q   = m >> k;
		q_n = q[NV_W-1:0];
		return neg ? $signed(-q_n) : $signed(q_n);
	endfunction

	function automatic logic [63:0] udiv(input logic [63:0] a, input logic [63:0] b);
		logic [63:0] r;
		logic [63:0] q;
		r = '0;
		q = '0;
		for (int i = 63; i >= 0; i--) begin
			r = {r[62:0], a[i]};
			if (r >= b) begin
				r    = r - b;
				q[i] = 1'b1;
			end
		end
		return q;
	endfunction

	function automatic logic signed [63:0] atan_pow2_q60(input int i);
		logic signed [63:0] sum;
		logic [63:0]        t;
		logic               neg;
		sum = '0;
		neg = 1'b0;
		for (int n = 1; n < 61; n += 2) begin
			if (i * n <= 60) begin
				t   = udiv(64'd1 << (60 - i * n), 64'(n));
				sum = neg ? sum - $signed(t) : sum + $signed(t);
				neg = ~neg;
			end
		end
		return sum;
	endfunction

	function automatic logic signed [63:0] atan_third_q60();
		logic [63:0]        p;
		logic [63:0]        n;
		logic [63:0]        t;
		logic signed [63:0] sum;
		logic               neg;
		p   = (64'd1 << 60) / 64'd3;
		n   = 64'd1;
		sum = '0;
		neg = 1'b0;
		for (int it = 0; it < 40; it++) begin
			if (p != '0) begin
				t   = udiv(p, n);
				sum = neg ? sum - $signed(t) : sum + $signed(t);
				neg = ~neg;
				p   = p / 64'd9;
				n   = n + 64'd2;
			end
		end
		return sum;
	endfunction

	function automatic logic [63:0] turn_units(input logic [63:0] a, input logic [63:0] b);
		logic [63:0] r;
		logic [63:0] q;
		r = a;
		q = '0;
		for (int i = 0; i < 33; i++) begin
			r = r << 1;
			q = q << 1;
			if (r >= b) begin
				r = r - b;
				q = q | 64'd1;
			end
		end
		return (q + 64'd1) >> 1;
	endfunction

	function automatic rot_tab_t build_rot_table();
		rot_tab_t           tab;
		logic signed [63:0] quarter;
		logic [63:0]        pi_q;
		quarter = atan_pow2_q60(1) + atan_third_q60();
		pi_q    = 64'(quarter) << 2;
		tab[0]  = Z_W'(turn_units(64'(quarter), pi_q));
		for (int i = 1; i < CORDIC_STEPS; i++) begin
			tab[i] = Z_W'(turn_units(64'(atan_pow2_q60(i)), pi_q));
		end
		return tab;
	endfunction

	localparam rot_tab_t ROT_TABLE = build_rot_table();

endpackage

@@ rtl/dihedral_angle_3d_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dihedral_angle_3d_top
// Signed torsion angle of four 3-D points, in degrees as Q8.16.
// ----------------------------------------------------------------------------
// The block takes one point quadruple in every clock cycle (busy is always
// low) and shows its result for one cycle on strobe; the receiver cannot
// stall it. The pipeline holds sixteen stages of differences, cross and dot
// products and block normalization, a 32-stage square root, a 33-stage
// CORDIC and two output stages.
module dihedral_angle_3d_top (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 start,
	output logic                                 busy,
	input  logic signed [dha_pkg::COORD_W-1:0]   a_x,
	input  logic signed [dha_pkg::COORD_W-1:0]   a_y,
	input  logic signed [dha_pkg::COORD_W-1:0]   a_z,
	input  logic signed [dha_pkg::COORD_W-1:0]   b_x,
	input  logic signed [dha_pkg::COORD_W-1:0]   b_y,
	input  logic signed [dha_pkg::COORD_W-1:0]   b_z,
	input  logic signed [dha_pkg::COORD_W-1:0]   c_x,
	input  logic signed [dha_pkg::COORD_W-1:0]   c_y,
	input  logic signed [dha_pkg::COORD_W-1:0]   c_z,
	input  logic signed [dha_pkg::COORD_W-1:0]   d_x,
	input  logic signed [dha_pkg::COORD_W-1:0]   d_y,
	input  logic signed [dha_pkg::COORD_W-1:0]   d_z,
	output logic                                 strobe,
	output logic signed [dha_pkg::ANGLE_W-1:0]   angle_deg,
	output logic                                 undefined
);

	localparam int LATENCY = 16 + dha_pkg::SQRT_STEPS + 1 + dha_pkg::CORDIC_STEPS + 1 + 2;
	localparam int DW = dha_pkg::DIFF_W;
	localparam int NW = dha_pkg::NV_W;
	localparam int PW = dha_pkg::PROD_W;
	localparam int GW = dha_pkg::DOT_W;

	logic signed [dha_pkg::COORD_W-1:0] pt [4][3];

	logic [16:1] v_s;

	logic [DW-1:0]              d_s1  [3][3];
	logic [DW-1:0]              dm_s2 [3][3];
	logic                       dn_s2 [3][3];
	logic [DW-1:0]              dm_s3 [3][3];
	logic                       dn_s3 [3][3];
	logic [dha_pkg::K_W-1:0]    dk_s3 [3];
	logic signed [NW-1:0]       dv_s4 [3][3];

	logic signed [PW-1:0]       pr_s5 [2][6];
	logic signed [NW-1:0]       bc_s5 [3];
	logic signed [PW-1:0]       cr_s6 [2][3];
	logic signed [NW-1:0]       bc_s6 [3];
	logic [PW-1:0]              cm_s7 [2][3];
	logic                       cn_s7 [2][3];
	logic signed [NW-1:0]       bc_s7 [3];
	logic                       undef_s7;
	logic [PW-1:0]              cm_s8 [2][3];
	logic                       cn_s8 [2][3];
	logic [dha_pkg::K_W-1:0]    ck_s8 [2];
	logic signed [NW-1:0]       bc_s8 [3];
	logic                       undef_s8;
	logic signed [NW-1:0]       uv_s9 [2][3];
	logic signed [NW-1:0]       bc_s9 [3];
	logic                       undef_s9;

	logic signed [PW-1:0]       xp_s10 [3];
	logic signed [PW-1:0]       wp_s10 [6];
	logic signed [NW-1:0]       bc_s10 [3];
	logic                       undef_s10;
	logic signed [GW-1:0]       g_s11 [4];
	logic signed [NW-1:0]       bc_s11 [3];
	logic                       undef_s11;
	logic [GW-1:0]              gm_s12 [4];
	logic                       gn_s12 [4];
	logic signed [NW-1:0]       bc_s12 [3];
	logic                       undef_s12;
	logic [GW-1:0]              gm_s13 [4];
	logic                       gn_s13 [4];
	logic [dha_pkg::K_W-1:0]    gk_s13;
	logic signed [NW-1:0]       bc_s13 [3];
	logic                       undef_s13;
	logic signed [NW-1:0]       gv_s14 [4];
	logic signed [NW-1:0]       bc_s14 [3];
	logic                       undef_s14;
	logic [PW-1:0]              sqp_s15 [3];
	logic signed [PW-1:0]       sp_s15 [3];
	logic signed [NW-1:0]       x_s15;
	logic                       undef_s15;
	logic [dha_pkg::SQ_W-1:0]   ssum_s16;
	dha_pkg::dha_sq_tag_t       tag_s16;

	logic                       sq_valid;
	logic [dha_pkg::ROOT_W-1:0] sq_root;
	dha_pkg::dha_sq_tag_t       sq_tag;
	dha_pkg::dha_cd_tag_t       cd_in_tag;

	logic                       cd_valid;
	logic signed [dha_pkg::Z_W-1:0] cd_z;
	dha_pkg::dha_cd_tag_t       cd_tag;

	logic                       v_s17;
	logic [dha_pkg::ANGLE_W-1:0] deg_s17;
	dha_pkg::dha_cd_tag_t       tag_s17;

	logic [dha_pkg::ZC_W-1:0]   zc;
	logic [dha_pkg::DEG_W-1:0]  deg_full;

	assign busy = 1'b0;

	assign pt[0][0] = a_x;  assign pt[0][1] = a_y;  assign pt[0][2] = a_z;
	assign pt[1][0] = b_x;  assign pt[1][1] = b_y;  assign pt[1][2] = b_z;
	assign pt[2][0] = c_x;  assign pt[2][1] = c_y;  assign pt[2][2] = c_z;
	assign pt[3][0] = d_x;  assign pt[3][1] = d_y;  assign pt[3][2] = d_z;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s    <= '0;
			v_s17  <= 1'b0;
			strobe <= 1'b0;
		end else begin
			v_s    <= {v_s[15:1], start & ~busy};
			v_s17  <= cd_valid;
			strobe <= v_s17;
		end
	end

	always_ff @(posedge clk) begin
		for (int e = 0; e < 3; e++) begin
			for (int c = 0; c < 3; c++) begin
				d_s1[e][c]  <= {pt[e+1][c][dha_pkg::COORD_W-1], pt[e+1][c]}
					- {pt[e][c][dha_pkg::COORD_W-1], pt[e][c]};
				dn_s2[e][c] <= d_s1[e][c][DW-1];
				dm_s2[e][c] <= d_s1[e][c][DW-1] ? -d_s1[e][c] : d_s1[e][c];
				dm_s3[e][c] <= dm_s2[e][c];
				dn_s3[e][c] <= dn_s2[e][c];
				dv_s4[e][c] <= dha_pkg::norm_apply(GW'(dm_s3[e][c]), dn_s3[e][c], dk_s3[e]);
			end
			dk_s3[e] <= dha_pkg::norm_k(GW'(dm_s2[e][0] | dm_s2[e][1] | dm_s2[e][2]));
		end
	end

	always_ff @(posedge clk) begin
		for (int e = 0; e < 2; e++) begin
			pr_s5[e][0] <= dv_s4[e][1] * dv_s4[e+1][2];
			pr_s5[e][1] <= dv_s4[e][2] * dv_s4[e+1][1];
			pr_s5[e][2] <= dv_s4[e][2] * dv_s4[e+1][0];
			pr_s5[e][3] <= dv_s4[e][0] * dv_s4[e+1][2];
			pr_s5[e][4] <= dv_s4[e][0] * dv_s4[e+1][1];
			pr_s5[e][5] <= dv_s4[e][1] * dv_s4[e+1][0];
			for (int c = 0; c < 3; c++) begin
				cr_s6[e][c] <= pr_s5[e][2*c] - pr_s5[e][2*c+1];
				cn_s7[e][c] <= cr_s6[e][c][PW-1];
				cm_s7[e][c] <= cr_s6[e][c][PW-1] ? -cr_s6[e][c] : cr_s6[e][c];
				cm_s8[e][c] <= cm_s7[e][c];
				cn_s8[e][c] <= cn_s7[e][c];
				uv_s9[e][c] <= dha_pkg::norm_apply(GW'(cm_s8[e][c]), cn_s8[e][c], ck_s8[e]);
			end
			ck_s8[e] <= dha_pkg::norm_k(GW'(cm_s7[e][0] | cm_s7[e][1] | cm_s7[e][2]));
		end
		undef_s7 <= ((cr_s6[0][0] == '0) && (cr_s6[0][1] == '0) && (cr_s6[0][2] == '0))
			|| ((cr_s6[1][0] == '0) && (cr_s6[1][1] == '0) && (cr_s6[1][2] == '0));
		undef_s8 <= undef_s7;
		undef_s9 <= undef_s8;
		for (int c = 0; c < 3; c++) begin
			bc_s5[c] <= dv_s4[1][c];
			bc_s6[c] <= bc_s5[c];
			bc_s7[c] <= bc_s6[c];
			bc_s8[c] <= bc_s7[c];
			bc_s9[c] <= bc_s8[c];
		end
	end

	always_ff @(posedge clk) begin
		for (int c = 0; c < 3; c++) begin
			xp_s10[c] <= uv_s9[0][c] * uv_s9[1][c];
		end
		wp_s10[0] <= uv_s9[0][1] * uv_s9[1][2];
		wp_s10[1] <= uv_s9[0][2] * uv_s9[1][1];
		wp_s10[2] <= uv_s9[0][2] * uv_s9[1][0];
		wp_s10[3] <= uv_s9[0][0] * uv_s9[1][2];
		wp_s10[4] <= uv_s9[0][0] * uv_s9[1][1];
		wp_s10[5] <= uv_s9[0][1] * uv_s9[1][0];

		g_s11[0] <= GW'(xp_s10[0]) + GW'(xp_s10[1]) + GW'(xp_s10[2]);
		for (int c = 0; c < 3; c++) begin
			g_s11[c+1] <= GW'(wp_s10[2*c]) - GW'(wp_s10[2*c+1]);
		end
		for (int g = 0; g < 4; g++) begin
			gn_s12[g] <= g_s11[g][GW-1];
			gm_s12[g] <= g_s11[g][GW-1] ? -g_s11[g] : g_s11[g];
			gn_s13[g] <= gn_s12[g];
			gm_s13[g] <= gm_s12[g];
			gv_s14[g] <= dha_pkg::norm_apply(gm_s13[g], gn_s13[g], gk_s13);
		end
		gk_s13 <= dha_pkg::norm_k(gm_s12[0] | gm_s12[1] | gm_s12[2] | gm_s12[3]);

		for (int c = 0; c < 3; c++) begin
			sqp_s15[c] <= gv_s14[c+1] * gv_s14[c+1];
			sp_s15[c]  <= bc_s14[c] * gv_s14[c+1];
		end
		x_s15 <= gv_s14[0];

		ssum_s16      <= GW'(sqp_s15[0]) + GW'(sqp_s15[1]) + GW'(sqp_s15[2]);
		tag_s16.s_pos <= (GW'(sp_s15[0]) + GW'(sp_s15[1]) + GW'(sp_s15[2])) > 0;
		tag_s16.x     <= x_s15;
		tag_s16.undef <= undef_s15;

		undef_s10 <= undef_s9;
		undef_s11 <= undef_s10;
		undef_s12 <= undef_s11;
		undef_s13 <= undef_s12;
		undef_s14 <= undef_s13;
		undef_s15 <= undef_s14;
		for (int c = 0; c < 3; c++) begin
			bc_s10[c] <= bc_s9[c];
			bc_s11[c] <= bc_s10[c];
			bc_s12[c] <= bc_s11[c];
			bc_s13[c] <= bc_s12[c];
			bc_s14[c] <= bc_s13[c];
		end
	end

	dha_isqrt u_isqrt (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (v_s[16]),
		.in_sq     (ssum_s16),
		.in_tag    (tag_s16),
		.out_valid (sq_valid),
		.out_root  (sq_root),
		.out_tag   (sq_tag)
	);

	assign cd_in_tag.undef = sq_tag.undef;
	assign cd_in_tag.s_pos = sq_tag.s_pos;

	dha_cordic u_cordic (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (sq_valid),
		.in_x      (sq_tag.x),
		.in_y      (sq_root),
		.in_tag    (cd_in_tag),
		.out_valid (cd_valid),
		.out_z     (cd_z),
		.out_tag   (cd_tag)
	);

	always_comb begin
		if (cd_z < 0) begin
			zc = '0;
		end else if (cd_z > dha_pkg::Z_FULL) begin
			zc = dha_pkg::ZC_W'(dha_pkg::Z_FULL);
		end else begin
			zc = dha_pkg::ZC_W'(cd_z);
		end
		deg_full = dha_pkg::DEG_W'(zc) * dha_pkg::DEG_W'(dha_pkg::DEG_SCALE)
			+ (dha_pkg::DEG_W'(1) << (dha_pkg::OUT_FRAC - 1));
	end

	always_ff @(posedge clk) begin
		deg_s17 <= deg_full[dha_pkg::OUT_FRAC +: dha_pkg::ANGLE_W];
		tag_s17 <= cd_tag;
		if (tag_s17.undef) begin
			angle_deg <= '0;
		end else if (tag_s17.s_pos) begin
			angle_deg <= $signed(deg_s17);
		end else begin
			angle_deg <= -$signed(deg_s17);
		end
		undefined <= tag_s17.undef;
	end

`ifndef SYNTHESIS
	a_strobe_follows_start: assert property (@(posedge clk) disable iff (!arst_n)
		strobe |-> $past(start, LATENCY))
		else $error("result without a matching item");

	a_angle_range: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && !undefined |-> (angle_deg <= dha_pkg::ANGLE_MAX)
			&& (angle_deg >= -dha_pkg::ANGLE_MAX))
		else $error("angle out of range");

	a_undef_zero: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && undefined |-> angle_deg == '0)
		else $error("undefined result carries an angle");
`endif

endmodule

@@ rtl/dha_isqrt.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dha_isqrt
// Pipelined integer square root, one result bit per stage, with a tag that
// travels alongside each item.
// ----------------------------------------------------------------------------
module dha_isqrt (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	input  logic [dha_pkg::SQ_W-1:0]          in_sq,
	input  dha_pkg::dha_sq_tag_t              in_tag,
	output logic                              out_valid,
	output logic [dha_pkg::ROOT_W-1:0]        out_root,
	output dha_pkg::dha_sq_tag_t              out_tag
);

	localparam int STEPS = dha_pkg::SQRT_STEPS;
	localparam int TOP   = 2 * (STEPS - 1);

	logic [STEPS:0]              vld_s;
	logic [dha_pkg::SQ_W-1:0]    rem_s [STEPS];
	logic [dha_pkg::SQ_W-1:0]    res_s [STEPS+1];
	dha_pkg::dha_sq_tag_t        tag_s [STEPS+1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else begin
			vld_s <= {vld_s[STEPS-1:0], in_valid};
		end
	end

	always_ff @(posedge clk) begin : sq_step
		logic [dha_pkg::SQ_W-1:0] bitv;
		logic [dha_pkg::SQ_W-1:0] trial;
		rem_s[0] <= in_sq;
		res_s[0] <= '0;
		tag_s[0] <= in_tag;
		for (int j = 0; j < STEPS - 1; j++) begin
			bitv  = dha_pkg::SQ_W'(1) << (TOP - 2 * j);
			trial = res_s[j] + bitv;
			if (rem_s[j] >= trial) begin
				rem_s[j+1] <= rem_s[j] - trial;
				res_s[j+1] <= (res_s[j] >> 1) + bitv;
			end else begin
				rem_s[j+1] <= rem_s[j];
				res_s[j+1] <= res_s[j] >> 1;
			end
			tag_s[j+1] <= tag_s[j];
		end
		trial = res_s[STEPS-1] + dha_pkg::SQ_W'(1);
		if (rem_s[STEPS-1] >= trial) begin
			res_s[STEPS] <= (res_s[STEPS-1] >> 1) + dha_pkg::SQ_W'(1);
		end else begin
			res_s[STEPS] <= res_s[STEPS-1] >> 1;
		end
		tag_s[STEPS] <= tag_s[STEPS-1];
	end

	assign out_valid = vld_s[STEPS];
	assign out_root  = res_s[STEPS][dha_pkg::ROOT_W-1:0];
	assign out_tag   = tag_s[STEPS];

endmodule

@@ rtl/dha_cordic.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dha_cordic
// Pipelined vectoring CORDIC: atan2(y, x) in units of 180/2^32 degrees,
// one rotation per stage.
// ----------------------------------------------------------------------------
module dha_cordic (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	input  logic signed [dha_pkg::NV_W-1:0]   in_x,
	input  logic [dha_pkg::ROOT_W-1:0]        in_y,
	input  dha_pkg::dha_cd_tag_t              in_tag,
	output logic                              out_valid,
	output logic signed [dha_pkg::Z_W-1:0]    out_z,
	output dha_pkg::dha_cd_tag_t              out_tag
);

	localparam int STEPS = dha_pkg::CORDIC_STEPS;

	logic [STEPS:0]                    vld_s;
	logic signed [dha_pkg::CX_W-1:0]   x_s [STEPS];
	logic signed [dha_pkg::CX_W-1:0]   y_s [STEPS];
	logic signed [dha_pkg::Z_W-1:0]    z_s [STEPS+1];
	dha_pkg::dha_cd_tag_t              tag_s [STEPS+1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else begin
			vld_s <= {vld_s[STEPS-1:0], in_valid};
		end
	end

	always_ff @(posedge clk) begin : cd_step
		logic signed [dha_pkg::CX_W-1:0] dx;
		logic signed [dha_pkg::CX_W-1:0] dy;
		logic signed [dha_pkg::Z_W-1:0]  ang;
		if (in_x < 0) begin
			x_s[0] <= $signed(dha_pkg::CX_W'(in_y));
			y_s[0] <= -dha_pkg::CX_W'(in_x);
			z_s[0] <= dha_pkg::Z_RIGHT;
		end else begin
			x_s[0] <= dha_pkg::CX_W'(in_x);
			y_s[0] <= $signed(dha_pkg::CX_W'(in_y));
			z_s[0] <= '0;
		end
		tag_s[0] <= in_tag;
		for (int i = 0; i < STEPS - 1; i++) begin
			dx  = y_s[i] >>> i;
			dy  = x_s[i] >>> i;
			ang = $signed(dha_pkg::ROT_TABLE[i]);
			if (y_s[i] >= 0) begin
				x_s[i+1] <= x_s[i] + dx;
				y_s[i+1] <= y_s[i] - dy;
				z_s[i+1] <= z_s[i] + ang;
			end else begin
				x_s[i+1] <= x_s[i] - dx;
				y_s[i+1] <= y_s[i] + dy;
				z_s[i+1] <= z_s[i] - ang;
			end
			tag_s[i+1] <= tag_s[i];
		end
		ang = $signed(dha_pkg::ROT_TABLE[STEPS-1]);
		if (y_s[STEPS-1] >= 0) begin
			z_s[STEPS] <= z_s[STEPS-1] + ang;
		end else begin
			z_s[STEPS] <= z_s[STEPS-1] - ang;
		end
		tag_s[STEPS] <= tag_s[STEPS-1];
	end

	assign out_valid = vld_s[STEPS];
	assign out_z     = z_s[STEPS];
	assign out_tag   = tag_s[STEPS];

endmodule
